// File: rtl/core/ftpid_pkg.sv
// Types and constants for the fuzzy self-tuning PID controller.
// Used by fuzzy_tuned_pid_controller; depends on nothing.
`default_nettype none
package ftpid_pkg;

   typedef struct packed {
      logic [15:0] setpoint;
      logic [15:0] measured;
   } req_type;

   typedef struct packed {
      logic [9:0] drive;
      logic       heat_on;
   } rsp_type;

   localparam logic [9:0] LIMIT_RESET = 10'd200;

   // rule tables, two-bit levels, indexed [e segment][ec segment]
   typedef logic [1:0] lvl_type;

   function automatic lvl_type rom_p(input logic [2:0] e, input logic [2:0] c);
      logic [13:0] row;
      row = 14'h0;
      unique case (e)
         3'd0: row = {2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3};
         3'd1: row = {2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2};
         3'd2: row = {2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1};
         3'd3: row = {2'd1,2'd1,2'd0,2'd1,2'd0,2'd1,2'd1};
         3'd4: row = {2'd0,2'd0,2'd1,2'd0,2'd0,2'd1,2'd0};
         3'd5: row = {2'd0,2'd1,2'd0,2'd1,2'd0,2'd0,2'd2};
         3'd6: row = {2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3};
         default: row = 14'h0;
      endcase
      return (c < 3'd7) ? row[2*(6-c) +: 2] : 2'd0;
   endfunction

   function automatic lvl_type rom_i(input logic [2:0] e, input logic [2:0] c);
      lvl_type v;
      v = 2'd0;
      if (e == 3'd6) v = 2'd3;
      else if (e == 3'd5 && c == 3'd0) v = 2'd2;
      else if (e == 3'd5 && c == 3'd6) v = 2'd1;
      return v;
   endfunction

   function automatic lvl_type rom_d(input logic [2:0] e, input logic [2:0] c);
      logic [13:0] row;
      row = 14'h0;
      unique case (e)
         3'd0: row = {2'd3,2'd3,2'd3,2'd2,2'd2,2'd2,2'd2};
         3'd1: row = {2'd2,2'd2,2'd2,2'd1,2'd1,2'd1,2'd1};
         3'd2: row = {2'd1,2'd1,2'd2,2'd1,2'd1,2'd2,2'd1};
         3'd3: row = {2'd1,2'd1,2'd0,2'd1,2'd0,2'd1,2'd1};
         3'd4: row = {2'd1,2'd1,2'd0,2'd0,2'd0,2'd1,2'd1};
         3'd5: row = {2'd2,2'd2,2'd1,2'd0,2'd1,2'd1,2'd1};
         3'd6: row = {2'd3,2'd3,2'd3,2'd3,2'd2,2'd3,2'd2};
         default: row = 14'h0;
      endcase
      return (c < 3'd7) ? row[2*(6-c) +: 2] : 2'd0;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/fuzzy_tuned_pid_controller.sv
// Fuzzy self-tuning PID controller, top level.
// Depends on ftpid_pkg.
//
//   channel  | ports                     | payload
//   req      | req_valid / req_ready     | req_data   (setpoint, measured)
//   rsp      | rsp_valid / rsp_ready     | rsp_data   (drive, heat_on)
//   csr      | csr_valid / csr_ready     | csr_data   (output_limit)
//
// One item runs through S_SUM, the bit-serial shift-add multiplier (three products), the
// restoring divide of the error by five, S_FUZ and the restoring divide of the I-gain
// level sum by one hundred before the next item is accepted. The result is registered
// in S_FUZ, before the divide by one hundred.
// A result waits in its output register; the next item is taken meanwhile and holds
// before its own result until the waiting one has left.
// Synchronous reset clears state, gains and the limit to 200.
`default_nettype none
module fuzzy_tuned_pid_controller
   import ftpid_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SUM_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [9:0] csr_data
);

   localparam int GPW = FRAC_BITS + 5;   // gain_p width
   localparam int GIW = FRAC_BITS;       // gain_i width
   localparam int GDW = FRAC_BITS + 2;   // gain_d width
   localparam int MW  = (SUM_WIDTH > 19) ? SUM_WIDTH : 19; // multiplicand width
   localparam int AW  = MW + GPW + 3;    // accumulator width
   localparam int CW  = $clog2(AW + 2);
   localparam int SW  = FRAC_BITS + 3;   // level sum width
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_MUL, S_DIV5, S_FUZ, S_DIV100, S_OUT
   } state_type;

   state_type state_ff;
   logic [9:0] limit_ff;
   logic signed [16:0] prev_ff, err_ff;
   logic signed [17:0] delta_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic [GPW-1:0] gp_ff;
   logic [GIW-1:0] gi_ff;
   logic [GDW-1:0] gd_ff;
   logic [1:0] term_ff;
   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] mcand_ff;     // magnitude, shifted left each cycle
   logic [GPW-1:0] mplier_ff;   // gain, shifted right each cycle
   logic mneg_ff;
   logic signed [AW:0] acc_ff;
   logic [AW-1:0] imag_ff;      // unsigned gain*|operand| product, reused as dividend/quotient in S_DIV100
   logic [16:0] dq_ff;          // division quotient/dividend
   logic [SW+6:0] drem_ff;
   logic [2:0] rem5_ff;
   logic [SW-1:0] sp_ff, si_ff, sd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // error sum with saturation
   logic signed [SUM_WIDTH:0] sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   always_comb begin
      sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff} + (SUM_WIDTH+1)'(err_ff);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      else
         sum_sat = sum_wide[SUM_WIDTH-1:0];
   end

   // multiplier step
   logic [AW-1:0] prod_add;
   assign prod_add = mplier_ff[0] ? mcand_ff : '0;

   // magnitude helpers
   function automatic logic [MW-1:0] mag18(input logic signed [17:0] v);
      logic [17:0] a;
      a = v[17] ? 18'(-v) : 18'(v);
      return MW'(a);
   endfunction

   logic [SUM_WIDTH-1:0] sum_mag;
   assign sum_mag = sum_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_ff) : SUM_WIDTH'(sum_ff);

   // fuzzy membership from quotient/remainder
   logic [2:0] pe, pc;
   logic [FRAC_BITS:0] me0, mc0;
   always_comb begin
      // e segment
      if (err_ff < -17'sd15) begin
         pe = 3'd0; me0 = ONE;
      end else if (err_ff >= 17'sd15) begin
         pe = 3'd5; me0 = '0;
      end else begin
         pe = dq_ff[2:0];
         // round((5-r)*2^F/5) as table of r: r in 0..4
         unique case (rem5_ff)
            3'd0: me0 = ONE;
            3'd1: me0 = (FRAC_BITS+1)'(((FRAC_BITS+3)'(4) << FRAC_BITS) / 5
                        + (((((FRAC_BITS+3)'(4) << FRAC_BITS) % 5) >= 3) ? 1 : 0));
            3'd2: me0 = (FRAC_BITS+1)'(((FRAC_BITS+3)'(3) << FRAC_BITS) / 5
                        + (((((FRAC_BITS+3)'(3) << FRAC_BITS) % 5) >= 3) ? 1 : 0));
            3'd3: me0 = (FRAC_BITS+1)'(((FRAC_BITS+3)'(2) << FRAC_BITS) / 5
                        + (((((FRAC_BITS+3)'(2) << FRAC_BITS) % 5) >= 3) ? 1 : 0));
            3'd4: me0 = (FRAC_BITS+1)'(((FRAC_BITS+3)'(1) << FRAC_BITS) / 5
                        + (((((FRAC_BITS+3)'(1) << FRAC_BITS) % 5) >= 3) ? 1 : 0));
            default: me0 = '0;
         endcase
      end
      // ec: integer, memberships 0 or 1
      if (delta_ff < -18'sd3) begin
         pc = 3'd0; mc0 = ONE;
      end else if (delta_ff >= 18'sd3) begin
         pc = 3'd5; mc0 = '0;
      end else begin
         pc = 3'(delta_ff + 18'sd3); mc0 = ONE;
      end
   end

   logic [SW-1:0] w0, w2;
   logic [FRAC_BITS:0] me1;
   assign me1 = ONE - me0;
   // mc0 is 0 or ONE: weights collapse to me0/me1 on one column
   logic [2:0] pcx;
   assign pcx = (mc0 == ONE) ? pc : 3'(pc + 3'd1);
   assign w0 = SW'(me0);
   assign w2 = SW'(me1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= LIMIT_RESET;
         prev_ff <= '0; sum_ff <= '0;
         gp_ff <= '0; gi_ff <= '0; gd_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0; term_ff <= '0;
      end else begin
         if (csr_valid) limit_ff <= csr_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  err_ff <= 17'({1'b0, req_data.setpoint}) - 17'({1'b0, req_data.measured});
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff <= sum_sat;
               delta_ff <= 18'(err_ff) - 18'(prev_ff);
               prev_ff <= err_ff;
               acc_ff <= '0;
               term_ff <= 2'd0;
               cnt_ff <= '0;
               mcand_ff <= AW'(mag18(18'(err_ff)));
               mneg_ff <= err_ff[16];
               mplier_ff <= gp_ff;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (cnt_ff == CW'(GPW)) begin
                  cnt_ff <= '0;
                  unique case (term_ff)
                     2'd0: begin
                        acc_ff <= mneg_ff ? acc_ff - (AW+1)'(imag_ff)
                                          : acc_ff + (AW+1)'(imag_ff);
                        mcand_ff <= AW'(mag18(delta_ff));
                        mneg_ff <= delta_ff[17];
                        mplier_ff <= GPW'(gd_ff);
                     end
                     2'd1: begin
                        acc_ff <= mneg_ff ? acc_ff - (AW+1)'(imag_ff)
                                          : acc_ff + (AW+1)'(imag_ff);
                        mcand_ff <= AW'(sum_mag);
                        mneg_ff <= sum_ff[SUM_WIDTH-1];
                        mplier_ff <= GPW'(gi_ff);
                     end
                     default: begin
                        // add the gain_i*|sum| product with the sign of the sum, then start the divide by five
                        acc_ff <= mneg_ff ? acc_ff - (AW+1)'(imag_ff)
                                          : acc_ff + (AW+1)'(imag_ff);
                        dq_ff <= 17'(err_ff + 17'sd15);
                        drem_ff <= '0; rem5_ff <= '0;
                        state_ff <= S_DIV5;
                     end
                  endcase
                  imag_ff <= '0;
                  term_ff <= term_ff + 2'd1;
               end else begin
                  if (cnt_ff == '0) imag_ff <= prod_add;
                  else imag_ff <= imag_ff + prod_add;
                  mcand_ff <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_DIV5: begin
               // restoring divide of (err+15) by 5, one bit per cycle
               if (cnt_ff == CW'(17)) begin
                  state_ff <= S_FUZ;
               end else begin
                  if ({rem5_ff, dq_ff[16]} >= 4'd5) begin
                     rem5_ff <= 3'({rem5_ff, dq_ff[16]} - 4'd5);
                     dq_ff <= {dq_ff[15:0], 1'b1};
                  end else begin
                     rem5_ff <= {rem5_ff[1:0], dq_ff[16]};
                     dq_ff <= {dq_ff[15:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_FUZ: begin
               // holds while the previous result still waits
               if (!rsp_valid_ff) begin
                  begin : drive_out
                     logic signed [AW:0] u;
                     logic [AW:0] ua;
                     logic neg;
                     neg = acc_ff[AW];
                     ua = neg ? (AW+1)'(-acc_ff) : (AW+1)'(acc_ff);
                     ua = ua >> FRAC_BITS;
                     u = neg ? -$signed(ua) : $signed(ua);
                     rsp_ff.heat_on <= !u[AW];
                     rsp_ff.drive <= (ua > (AW+1)'(limit_ff)) ? limit_ff : 10'(ua);
                  end
                  rsp_valid_ff <= 1'b1;
                  sp_ff <= w0 * SW'(rom_p(pe, pcx)) + w2 * SW'(rom_p(3'(pe + 3'd1), pcx));
                  si_ff <= w0 * SW'(rom_i(pe, pcx)) + w2 * SW'(rom_i(3'(pe + 3'd1), pcx));
                  sd_ff <= w0 * SW'(rom_d(pe, pcx)) + w2 * SW'(rom_d(3'(pe + 3'd1), pcx));
                  cnt_ff <= '0;
                  state_ff <= S_DIV100;
               end
            end
            S_DIV100: begin
               // (si+50)/100 restoring, one bit per cycle
               if (cnt_ff == '0) begin
                  drem_ff <= '0;
                  imag_ff <= AW'(si_ff + SW'(50));
                  cnt_ff <= cnt_ff + CW'(1);
               end else if (cnt_ff == CW'(SW + 1)) begin
                  gp_ff <= GPW'({sp_ff, 3'b000});
                  gd_ff <= GDW'(sd_ff);
                  gi_ff <= GIW'(imag_ff[SW-1:0]);
                  state_ff <= S_IDLE;
               end else begin
                  if ({drem_ff[SW+5:0], imag_ff[SW-1]} >= (SW+7)'(100)) begin
                     drem_ff <= {drem_ff[SW+5:0], imag_ff[SW-1]} - (SW+7)'(100);
                     imag_ff <= {imag_ff[AW-2:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[SW+5:0], imag_ff[SW-1]};
                     imag_ff <= {imag_ff[AW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_drive_le_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive <= limit_ff) else $error("drive above limit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

endmodule
`default_nettype wire

// File: dv/tb_fuzzy_tuned_pid_controller.sv
// Self-checking testbench for fuzzy_tuned_pid_controller: directed and random samples
// against a built-in model of the PID loop with fuzzy gain tuning.
// Depends on ftpid_pkg and the controller RTL.
`default_nettype none
module tb_fuzzy_tuned_pid_controller;
   import ftpid_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  FRAC = 16;
   localparam int  SUMW = 32;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint CAP = longint'(1) << 62;
   localparam int  CYCLE_LIMIT = 10000000;
   localparam int  SETTLE = 400;
   localparam int  RANDOM_ITEMS = 1830;

   localparam int LVL_P [7][7] = '{
      '{3,3,3,3,3,3,3}, '{2,2,2,2,1,2,2}, '{1,1,1,1,1,1,1}, '{1,1,0,1,0,1,1},
      '{0,0,1,0,0,1,0}, '{0,1,0,1,0,0,2}, '{3,3,3,3,3,3,3}};
   localparam int LVL_I [7][7] = '{
      '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0},
      '{0,0,0,0,0,0,0}, '{2,0,0,0,0,0,1}, '{3,3,3,3,3,3,3}};
   localparam int LVL_D [7][7] = '{
      '{3,3,3,2,2,2,2}, '{2,2,2,1,1,1,1}, '{1,1,2,1,1,2,1}, '{1,1,0,1,0,1,1},
      '{1,1,0,0,0,1,1}, '{2,2,1,0,1,1,1}, '{3,3,3,3,2,3,2}};

   class pid_scoreboard;
      rsp_type drive_q[$];
      longint  limit, prev_err, err_acc, kp, ki, kd;
      int      errors;

      function new();
         limit = LIMIT_RESET; prev_err = 0; err_acc = 0;
         kp = 0; ki = 0; kd = 0; errors = 0;
      endfunction

      function void grade(longint x, longint dv, output longint mu, output int seg);
         longint off, q;
         if (x < -3 * dv) begin
            mu = ONE; seg = 0;
         end else if (x >= 3 * dv) begin
            mu = 0; seg = 5;
         end else begin
            off = x + 3 * dv;
            q = off / dv;
            mu = (((dv - (off - q * dv)) << FRAC) + dv / 2) / dv;
            seg = int'(q);
         end
      endfunction

      function void note(req_type d);
         longint err, dlt, part, mag, term, total, u, me, mc, sp_, si_, sd_;
         longint w [4];
         int     pe, pc;
         rsp_type r;
         err = longint'(d.setpoint) - longint'(d.measured);
         err_acc = err_acc + err;
         if (err_acc > (longint'(1) << (SUMW - 1)) - 1) err_acc = (longint'(1) << (SUMW - 1)) - 1;
         if (err_acc < -(longint'(1) << (SUMW - 1))) err_acc = -(longint'(1) << (SUMW - 1));
         dlt = err - prev_err;
         prev_err = err;
         part = kp * err + kd * dlt;
         mag = err_acc < 0 ? -err_acc : err_acc;
         if (ki == 0 || mag == 0) term = 0;
         else if (mag > CAP / ki) term = CAP;
         else term = ki * mag;
         if (err_acc < 0) term = -term;
         total = part + term;
         u = total >= 0 ? (total >>> FRAC) : -((-total) >>> FRAC);
         mag = u < 0 ? -u : u;
         r.drive = 10'(mag > limit ? limit : mag);
         r.heat_on = u >= 0;
         drive_q.push_back(r);
         grade(err, 5, me, pe);
         grade(dlt, 1, mc, pc);
         w[0] = (me * mc) >>> FRAC;
         w[1] = (me * (ONE - mc)) >>> FRAC;
         w[2] = ((ONE - me) * mc) >>> FRAC;
         w[3] = ((ONE - me) * (ONE - mc)) >>> FRAC;
         sp_ = w[0]*LVL_P[pe][pc] + w[1]*LVL_P[pe][pc+1]
             + w[2]*LVL_P[pe+1][pc] + w[3]*LVL_P[pe+1][pc+1];
         si_ = w[0]*LVL_I[pe][pc] + w[1]*LVL_I[pe][pc+1]
             + w[2]*LVL_I[pe+1][pc] + w[3]*LVL_I[pe+1][pc+1];
         sd_ = w[0]*LVL_D[pe][pc] + w[1]*LVL_D[pe][pc+1]
             + w[2]*LVL_D[pe+1][pc] + w[3]*LVL_D[pe+1][pc+1];
         kp = 8 * sp_;
         ki = (si_ + 50) / 100;
         kd = sd_;
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (drive_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: drive %0d heat_on %0d",
                                       got.drive, got.heat_on);
            return;
         end
         want = drive_q.pop_front();
         if (got.drive !== want.drive || got.heat_on !== want.heat_on) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: drive exp %0d got %0d, heat_on exp %0d got %0d",
                        want.drive, got.drive, want.heat_on, got.heat_on);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   rsp_type    rsp_data;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [9:0] csr_data = '0;

   pid_scoreboard sb = new();
   int  cycles = 0;
   int  hold_off = 0;
   bit  busy_mode = 0;

   fuzzy_tuned_pid_controller dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note(req_data);
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if (csr_valid && csr_ready) sb.limit = csr_data;
      end
   end

   function automatic int pick_gap();
      int p;
      if (busy_mode) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // receiver: random stalls plus the occasional long hold-off
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
         end
      end
   end

   task automatic send_sample(logic [15:0] sp, logic [15:0] ms);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{setpoint: sp, measured: ms};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(logic [9:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic random_sample();
      int sp, ms, kind;
      kind = $urandom_range(0, 9);
      sp = $urandom_range(0, 65535);
      if (kind < 2) ms = $urandom_range(0, 65535);
      else if (kind < 4) ms = sp + $urandom_range(0, 200) - 100;
      else ms = sp + $urandom_range(0, 40) - 20;
      if (ms < 0) ms = 0;
      if (ms > 65535) ms = 65535;
      send_sample(16'(sp), 16'(ms));
   endtask

   initial begin
      logic [9:0] limits [5];
      int n;
      limits = '{10'd0, 10'd1023, 10'd1, 10'd0, 10'd200};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, segment edges, delta extremes
      send_sample(16'd0, 16'd0);
      send_sample(16'hFFFF, 16'd0);
      send_sample(16'd0, 16'hFFFF);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'd0);
      for (int e = -16; e <= 16; e += 2) send_sample(16'd1000, 16'(1000 - e));
      send_sample(16'd1003, 16'd1000);
      send_sample(16'd1000, 16'd1003);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         limits[3] = 10'($urandom_range(2, 1022));
         write_limit(limits[ph]);
         n = 0;
         while (n < RANDOM_ITEMS / 5) begin
            busy_mode = (ph == 2 && n < 100);
            if (ph == 1 && n == 50) hold_off = 3000;
            random_sample();
            n++;
         end
         busy_mode = 0;
         drain();
      end

      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
